/* sv/brs_pkg.sv */
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the biquadratic root solver
// Result codes, the result pattern that travels with each request, and the
// default widths of the coefficient and root fields.
// ----------------------------------------------------------------------------
package brs_pkg;

	// Default coefficient width and number of fraction bits of a root.
	localparam int DEF_COEF_WIDTH = 16;
	localparam int DEF_FRAC_BITS  = 16;

	// Fixed widths of the result fields.
	localparam int CODE_WIDTH = 3;
	localparam int ROOT_WIDTH = 32;

	// Largest root magnitude; larger roots saturate to it.
	localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = 32'h7FFF_FFFF;

	// Result case codes.
	typedef enum logic [CODE_WIDTH-1:0] {
		CODE_ALL_REAL  = 3'd0,
		CODE_INCONS    = 3'd1,
		CODE_NO_ROOT   = 3'd2,
		CODE_ROOT_ZERO = 3'd3,
		CODE_TWO       = 3'd4,
		CODE_FOUR      = 3'd5
	} brs_code_t;

	// Pattern of results for one request.
	// KIND_SOLVE marks a full quadratic whose roots are not yet sorted out.
	typedef enum logic [2:0] {
		KIND_NONE  = 3'd0,
		KIND_ZERO  = 3'd1,
		KIND_PAIR1 = 3'd2,
		KIND_PAIR2 = 3'd3,
		KIND_QUAD  = 3'd4,
		KIND_SOLVE = 3'd5
	} brs_kind_t;

	typedef struct packed {
		brs_code_t code;
		brs_kind_t kind;
	} brs_tag_t;

endpackage

/* sv/brs_in_if.sv */
// ----------------------------------------------------------------------------
// brs_in_if: coefficient request channel
// Valid/ready channel that carries the three coefficients of one equation.
// ----------------------------------------------------------------------------
interface brs_in_if #(
	parameter int COEF_WIDTH = brs_pkg::DEF_COEF_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_quartic;
	logic signed [COEF_WIDTH-1:0] coef_square;
	logic signed [COEF_WIDTH-1:0] coef_constant;

	modport source (output valid, output coef_quartic, output coef_square,
		output coef_constant, input ready);
	modport sink (input valid, input coef_quartic, input coef_square,
		input coef_constant, output ready);
endinterface

/* sv/brs_out_if.sv */
// ----------------------------------------------------------------------------
// brs_out_if: root result channel
// Valid/ready channel that carries one result: case code, root and flags.
// ----------------------------------------------------------------------------
interface brs_out_if;
	logic                                   valid;
	logic                                   ready;
	logic [brs_pkg::CODE_WIDTH-1:0]         case_code;
	logic signed [brs_pkg::ROOT_WIDTH-1:0]  root_value;
	logic                                   root_valid;
	logic                                   last_result;

	modport source (output valid, output case_code, output root_value,
		output root_valid, output last_result, input ready);
	modport sink (input valid, input case_code, input root_value,
		input root_valid, input last_result, output ready);
endinterface

/* sv/biquadratic_root_solver_top.sv */
// ----------------------------------------------------------------------------
// biquadratic_root_solver_top: real roots of a*x^4 + b*x^2 + c = 0
// Takes one coefficient request per cycle on coefs, unless held, and returns
// its real roots as signed fixed point with FRAC_BITS fraction bits on roots.
//
// Use: a request carries coef_quartic, coef_square and coef_constant. It
// yields one result (no root, all reals, inconsistent, or the root zero),
// two results (+r, -r) or four (+r1, -r1, +r2, -r2); last_result marks the
// final one. Each request passes brs_front, the discriminant square root,
// brs_split, the lane dividers and the lane square roots, each one bit a
// stage, and the result sequencer. Requests enter one per cycle while the
// sequencer can take one; the result channel sends one result per cycle
// while roots.ready is high, and holds a request until its last result.
// Reset clears all valid bits and the result sequencer; no clearing pass.
// When roots stalls, the whole pipeline holds and coefs.ready drops; no
// request or result is lost or repeated.
// ----------------------------------------------------------------------------
module biquadratic_root_solver_top #(
	parameter int COEF_WIDTH = brs_pkg::DEF_COEF_WIDTH,
	parameter int FRAC_BITS  = brs_pkg::DEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	brs_in_if.sink    coefs,
	brs_out_if.source roots
);

	localparam int CW   = COEF_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int XW   = CW + F + 2;
	localparam int DENW = CW + 1;
	localparam int RW   = 2 * CW + 2 * F + 1;
	localparam int SW   = (RW + 1) / 2;
	localparam int NW   = XW + F;
	localparam int LSW  = (NW + 1) / 2;
	localparam int TW   = $bits(brs_pkg::brs_tag_t);
	localparam int DW1  = TW + 2 + CW + DENW + XW;

	logic advance;

	logic              f_valid, f_an, f_bn;
	brs_pkg::brs_tag_t f_tag;
	logic [CW-1:0]     f_bm;
	logic [DENW-1:0]   f_den;
	logic [XW-1:0]     f_x1;
	logic [RW-1:0]     f_rad;

	logic              q_valid, q_an, q_bn;
	brs_pkg::brs_tag_t q_tag;
	logic [CW-1:0]     q_bm;
	logic [DENW-1:0]   q_den;
	logic [XW-1:0]     q_x1;
	logic [SW-1:0]     q_s;
	logic [DW1-1:0]    q_in_data, q_out_data;

	logic              p_valid;
	brs_pkg::brs_tag_t p_tag;
	logic [XW-1:0]     p_num1, p_num2;
	logic [DENW-1:0]   p_den;

	logic              d_valid;
	brs_pkg::brs_tag_t d_tag;
	logic [NW-1:0]     d_q1, d_q2;

	logic              r_valid;
	brs_pkg::brs_tag_t r_tag;
	logic [LSW-1:0]    r_1, r_2;

	assign coefs.ready = advance;

	// Decode and discriminant.
	brs_front #(
		.COEF_WIDTH (CW),
		.FRAC_BITS  (F)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (coefs.valid),
		.coef_a    (coefs.coef_quartic),
		.coef_b    (coefs.coef_square),
		.coef_c    (coefs.coef_constant),
		.out_valid (f_valid),
		.out_tag   (f_tag),
		.out_an    (f_an),
		.out_bn    (f_bn),
		.out_bm    (f_bm),
		.out_den   (f_den),
		.out_x1    (f_x1),
		.out_rad   (f_rad)
	);

	// Square root of the scaled discriminant.
	assign q_in_data = {f_tag, f_an, f_bn, f_bm, f_den, f_x1};
	assign {q_tag, q_an, q_bn, q_bm, q_den, q_x1} = q_out_data;

	brs_isqrt #(
		.RAD_WIDTH  (RW),
		.DATA_WIDTH (DW1)
	) u_disc_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (f_valid),
		.in_rad    (f_rad),
		.in_data   (q_in_data),
		.out_valid (q_valid),
		.out_root  (q_s),
		.out_data  (q_out_data)
	);

	// Numerators of the two values of x^2 and the result pattern.
	brs_split #(
		.COEF_WIDTH (CW),
		.FRAC_BITS  (F)
	) u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (q_valid),
		.in_tag    (q_tag),
		.in_an     (q_an),
		.in_bn     (q_bn),
		.in_bm     (q_bm),
		.in_den    (q_den),
		.in_x1     (q_x1),
		.in_s      (q_s),
		.out_valid (p_valid),
		.out_tag   (p_tag),
		.out_num1  (p_num1),
		.out_num2  (p_num2),
		.out_den   (p_den)
	);

	// Lane dividers: x^2 scaled by 2^(2F).
	brs_div #(
		.NUM_WIDTH  (NW),
		.DEN_WIDTH  (DENW),
		.DATA_WIDTH (TW)
	) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (p_valid),
		.in_num    ({p_num1, {F{1'b0}}}),
		.in_den    (p_den),
		.in_data   (p_tag),
		.out_valid (d_valid),
		.out_quot  (d_q1),
		.out_data  (d_tag)
	);

	brs_div #(
		.NUM_WIDTH  (NW),
		.DEN_WIDTH  (DENW),
		.DATA_WIDTH (TW)
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (p_valid),
		.in_num    ({p_num2, {F{1'b0}}}),
		.in_den    (p_den),
		.in_data   (p_tag),
		.out_valid (),
		.out_quot  (d_q2),
		.out_data  ()
	);

	// Lane square roots give the root magnitudes.
	brs_isqrt #(
		.RAD_WIDTH  (NW),
		.DATA_WIDTH (TW)
	) u_root1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (d_valid),
		.in_rad    (d_q1),
		.in_data   (d_tag),
		.out_valid (r_valid),
		.out_root  (r_1),
		.out_data  (r_tag)
	);

	brs_isqrt #(
		.RAD_WIDTH  (NW),
		.DATA_WIDTH (TW)
	) u_root2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (d_valid),
		.in_rad    (d_q2),
		.in_data   (d_tag),
		.out_valid (),
		.out_root  (r_2),
		.out_data  ()
	);

	// Result sequencer.
	brs_emit #(
		.LANE_WIDTH (LSW)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (r_valid),
		.in_tag   (r_tag),
		.in_r1    (r_1),
		.in_r2    (r_2),
		.take     (advance),
		.roots    (roots)
	);

endmodule

/* sv/brs_front.sv */
// ----------------------------------------------------------------------------
// brs_front: coefficient decode and discriminant
// Three stages: sign/magnitude split, products and case sorting, then the
// discriminant with the radicand for the square root that follows.
// ----------------------------------------------------------------------------
module brs_front #(
	parameter int COEF_WIDTH = brs_pkg::DEF_COEF_WIDTH,
	parameter int FRAC_BITS  = brs_pkg::DEF_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [COEF_WIDTH-1:0]           coef_a,
	input  logic signed [COEF_WIDTH-1:0]           coef_b,
	input  logic signed [COEF_WIDTH-1:0]           coef_c,
	output logic                                   out_valid,
	output brs_pkg::brs_tag_t                      out_tag,
	output logic                                   out_an,
	output logic                                   out_bn,
	output logic [COEF_WIDTH-1:0]                  out_bm,
	output logic [COEF_WIDTH:0]                    out_den,
	output logic [COEF_WIDTH+FRAC_BITS+1:0]        out_x1,
	output logic [2*COEF_WIDTH+2*FRAC_BITS:0]      out_rad
);

	localparam int CW   = COEF_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int XW   = CW + F + 2;
	localparam int DENW = CW + 1;
	localparam int PW   = 2 * CW;
	localparam int DSW  = 2 * CW + 2;
	localparam int RW   = 2 * CW + 2 * F + 1;

	logic [CW-1:0] a_raw, b_raw, c_raw;
	logic [CW-1:0] a_mag, b_mag, c_mag;

	logic          vld_s1, an_s1, bn_s1, cn_s1;
	logic [CW-1:0] am_s1, bm_s1, cm_s1;

	brs_pkg::brs_tag_t tag_c2;
	logic [DENW-1:0]   den_c2;
	logic [XW-1:0]     x1_c2;
	logic [PW-1:0]     bb_c2, ac_c2;

	logic              vld_s2, an_s2, bn_s2, acn_s2;
	brs_pkg::brs_tag_t tag_s2;
	logic [CW-1:0]     bm_s2;
	logic [DENW-1:0]   den_s2;
	logic [XW-1:0]     x1_s2;
	logic [PW-1:0]     bb_s2, ac_s2;

	logic [DSW-1:0]    d_c3;
	logic              dneg_c3, dzero_c3;
	brs_pkg::brs_tag_t tag_c3;
	logic [RW-1:0]     rad_c3;

	// Two's complement to sign and magnitude; the most negative code keeps
	// its bits, which read as its magnitude.
	assign a_raw = coef_a;
	assign b_raw = coef_b;
	assign c_raw = coef_c;
	assign a_mag = a_raw[CW-1] ? (~a_raw + CW'(1)) : a_raw;
	assign b_mag = b_raw[CW-1] ? (~b_raw + CW'(1)) : b_raw;
	assign c_mag = c_raw[CW-1] ? (~c_raw + CW'(1)) : c_raw;

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (en) begin
			an_s1 <= a_raw[CW-1];
			bn_s1 <= b_raw[CW-1];
			cn_s1 <= c_raw[CW-1];
			am_s1 <= a_mag;
			bm_s1 <= b_mag;
			cm_s1 <= c_mag;
		end
	end

	// Stage 2: products and sorting of the degenerate cases.
	assign bb_c2 = PW'(bm_s1) * PW'(bm_s1);
	assign ac_c2 = PW'(am_s1) * PW'(cm_s1);

	always_comb begin
		tag_c2.code = brs_pkg::CODE_FOUR;
		tag_c2.kind = brs_pkg::KIND_SOLVE;
		den_c2      = {am_s1, 1'b0};
		x1_c2       = XW'({bm_s1, {F{1'b0}}});
		priority if (am_s1 == '0 && bm_s1 == '0) begin
			tag_c2.code = (cm_s1 == '0) ? brs_pkg::CODE_ALL_REAL : brs_pkg::CODE_INCONS;
			tag_c2.kind = brs_pkg::KIND_NONE;
		end else if (am_s1 == '0) begin
			// Linear in x^2: t = -c/b.
			if (cm_s1 != '0 && cn_s1 == bn_s1) begin
				tag_c2.code = brs_pkg::CODE_NO_ROOT;
				tag_c2.kind = brs_pkg::KIND_NONE;
			end else begin
				tag_c2.code = brs_pkg::CODE_TWO;
				tag_c2.kind = brs_pkg::KIND_PAIR1;
			end
			den_c2 = DENW'(bm_s1);
			x1_c2  = XW'({cm_s1, {F{1'b0}}});
		end else if (bm_s1 == '0) begin
			// Pure quartic: t = -c/a.
			if (cm_s1 == '0) begin
				tag_c2.code = brs_pkg::CODE_ROOT_ZERO;
				tag_c2.kind = brs_pkg::KIND_ZERO;
			end else if (cn_s1 == an_s1) begin
				tag_c2.code = brs_pkg::CODE_NO_ROOT;
				tag_c2.kind = brs_pkg::KIND_NONE;
			end else begin
				tag_c2.code = brs_pkg::CODE_TWO;
				tag_c2.kind = brs_pkg::KIND_PAIR1;
			end
			den_c2 = DENW'(am_s1);
			x1_c2  = XW'({cm_s1, {F{1'b0}}});
		end else begin
			tag_c2.code = brs_pkg::CODE_FOUR;
			tag_c2.kind = brs_pkg::KIND_SOLVE;
		end
	end

	// Stage 2 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_c2;
			an_s2  <= an_s1;
			bn_s2  <= bn_s1;
			acn_s2 <= an_s1 ^ cn_s1;
			bm_s2  <= bm_s1;
			den_s2 <= den_c2;
			x1_s2  <= x1_c2;
			bb_s2  <= bb_c2;
			ac_s2  <= ac_c2;
		end
	end

	// Stage 3: discriminant b^2 - 4ac; its sign and zero test finish the
	// sorting of the full quadratic.
	assign d_c3     = acn_s2 ? (DSW'(bb_s2) + {ac_s2, 2'b00})
	                         : (DSW'(bb_s2) - {ac_s2, 2'b00});
	assign dneg_c3  = d_c3[DSW-1];
	assign dzero_c3 = (d_c3 == '0);

	always_comb begin
		tag_c3 = tag_s2;
		if (tag_s2.kind == brs_pkg::KIND_SOLVE) begin
			priority if (dneg_c3) begin
				tag_c3.code = brs_pkg::CODE_NO_ROOT;
				tag_c3.kind = brs_pkg::KIND_NONE;
			end else if (dzero_c3) begin
				// Double root t = -b/(2a).
				if (bn_s2 == an_s2) begin
					tag_c3.code = brs_pkg::CODE_NO_ROOT;
					tag_c3.kind = brs_pkg::KIND_NONE;
				end else begin
					tag_c3.code = brs_pkg::CODE_TWO;
					tag_c3.kind = brs_pkg::KIND_PAIR1;
				end
			end else begin
				tag_c3 = tag_s2;
			end
		end
		rad_c3 = (tag_c3.kind == brs_pkg::KIND_SOLVE) ? {d_c3[PW:0], {(2*F){1'b0}}} : '0;
	end

	// Stage 3 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s2;
		end
	end

	// Stage 3 payload.
	always_ff @(posedge clk) begin
		if (en) begin
			out_tag <= tag_c3;
			out_an  <= an_s2;
			out_bn  <= bn_s2;
			out_bm  <= bm_s2;
			out_den <= den_s2;
			out_x1  <= x1_s2;
			out_rad <= rad_c3;
		end
	end

endmodule

/* sv/brs_isqrt.sv */
// ----------------------------------------------------------------------------
// brs_isqrt: pipelined integer square root
// Floor square root, one result bit per stage, with a side payload that
// moves along with each request.
// ----------------------------------------------------------------------------
module brs_isqrt #(
	parameter int RAD_WIDTH  = 34,
	parameter int DATA_WIDTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [RAD_WIDTH-1:0]         in_rad,
	input  logic [DATA_WIDTH-1:0]        in_data,
	output logic                         out_valid,
	output logic [(RAD_WIDTH+1)/2-1:0]   out_root,
	output logic [DATA_WIDTH-1:0]        out_data
);

	localparam int NS   = (RAD_WIDTH + 1) / 2;
	localparam int RP   = 2 * NS;
	localparam int REMW = NS + 2;

	logic                  vld_s  [NS];
	logic [RP-1:0]         rad_s  [NS];
	logic [REMW-1:0]       rem_s  [NS];
	logic [NS-1:0]         root_s [NS];
	logic [DATA_WIDTH-1:0] dat_s  [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic                  vld_p;
		logic [RP-1:0]         rad_p;
		logic [REMW-1:0]       rem_p;
		logic [NS-1:0]         root_p;
		logic [DATA_WIDTH-1:0] dat_p;
		logic [REMW+1:0]       cur, trial;
		logic                  ge;

		if (k == 0) begin : g_first
			assign vld_p  = in_valid;
			assign rad_p  = RP'(in_rad);
			assign rem_p  = '0;
			assign root_p = '0;
			assign dat_p  = in_data;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign dat_p  = dat_s[k-1];
		end

		// Bring down the next two radicand bits and try 4*root + 1.
		assign cur   = {rem_p, rad_p[RP-1 -: 2]};
		assign trial = (REMW+2)'({root_p, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_p[RP-3:0], 2'b00};
				rem_s[k]  <= ge ? REMW'(cur - trial) : cur[REMW-1:0];
				root_s[k] <= {root_p[NS-2:0], ge};
				dat_s[k]  <= dat_p;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_root  = root_s[NS-1];
	assign out_data  = dat_s[NS-1];

endmodule

/* sv/brs_div.sv */
// ----------------------------------------------------------------------------
// brs_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage. Dividend bits shift out
// at the top of a register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module brs_div #(
	parameter int NUM_WIDTH  = 50,
	parameter int DEN_WIDTH  = 17,
	parameter int DATA_WIDTH = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [NUM_WIDTH-1:0]  in_num,
	input  logic [DEN_WIDTH-1:0]  in_den,
	input  logic [DATA_WIDTH-1:0] in_data,
	output logic                  out_valid,
	output logic [NUM_WIDTH-1:0]  out_quot,
	output logic [DATA_WIDTH-1:0] out_data
);

	localparam int NW = NUM_WIDTH;
	localparam int DW = DEN_WIDTH;

	logic                  vld_s [NW];
	logic [NW-1:0]         nq_s  [NW];
	logic [DW-1:0]         rem_s [NW];
	logic [DW-1:0]         den_s [NW];
	logic [DATA_WIDTH-1:0] dat_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic                  vld_p;
		logic [NW-1:0]         nq_p;
		logic [DW-1:0]         rem_p;
		logic [DW-1:0]         den_p;
		logic [DATA_WIDTH-1:0] dat_p;
		logic [DW:0]           cur;
		logic                  ge;

		if (k == 0) begin : g_first
			assign vld_p = in_valid;
			assign nq_p  = in_num;
			assign rem_p = '0;
			assign den_p = in_den;
			assign dat_p = in_data;
		end else begin : g_next
			assign vld_p = vld_s[k-1];
			assign nq_p  = nq_s[k-1];
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign dat_p = dat_s[k-1];
		end

		// Shift in the next dividend bit and subtract when it fits.
		assign cur = {rem_p, nq_p[NW-1]};
		assign ge  = (cur >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k]  <= {nq_p[NW-2:0], ge};
				rem_s[k] <= ge ? DW'(cur - {1'b0, den_p}) : cur[DW-1:0];
				den_s[k] <= den_p;
				dat_s[k] <= dat_p;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign out_quot  = nq_s[NW-1];
	assign out_data  = dat_s[NW-1];

endmodule

/* sv/brs_split.sv */
// ----------------------------------------------------------------------------
// brs_split: quadratic numerators and root selection
// Two stages: forms -b*2^F -/+ S, then takes magnitudes, decides which
// values of x^2 are not negative and fixes the result pattern.
// ----------------------------------------------------------------------------
module brs_split #(
	parameter int COEF_WIDTH = brs_pkg::DEF_COEF_WIDTH,
	parameter int FRAC_BITS  = brs_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  brs_pkg::brs_tag_t                in_tag,
	input  logic                             in_an,
	input  logic                             in_bn,
	input  logic [COEF_WIDTH-1:0]            in_bm,
	input  logic [COEF_WIDTH:0]              in_den,
	input  logic [COEF_WIDTH+FRAC_BITS+1:0]  in_x1,
	input  logic [COEF_WIDTH+FRAC_BITS:0]    in_s,
	output logic                             out_valid,
	output brs_pkg::brs_tag_t                out_tag,
	output logic [COEF_WIDTH+FRAC_BITS+1:0]  out_num1,
	output logic [COEF_WIDTH+FRAC_BITS+1:0]  out_num2,
	output logic [COEF_WIDTH:0]              out_den
);

	localparam int CW   = COEF_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int XW   = CW + F + 2;
	localparam int NBW  = XW + 1;
	localparam int DENW = CW + 1;

	logic [NBW-1:0] bsh_c, s_c, n1_c, n2_c;

	logic              vld_sa, an_sa;
	brs_pkg::brs_tag_t tag_sa;
	logic [DENW-1:0]   den_sa;
	logic [XW-1:0]     x1_sa;
	logic [NBW-1:0]    n1_sa, n2_sa;

	logic              neg1_c, neg2_c;
	logic [XW-1:0]     m1_c, m2_c, num1_c, num2_c;
	brs_pkg::brs_tag_t tag_c;

	// Stage A: N1 = -b*2^F - S and N2 = -b*2^F + S in two's complement.
	assign bsh_c = NBW'({in_bm, {F{1'b0}}});
	assign s_c   = NBW'(in_s);
	assign n1_c  = in_bn ? (bsh_c - s_c) : (NBW'(0) - bsh_c - s_c);
	assign n2_c  = in_bn ? (bsh_c + s_c) : (s_c - bsh_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
		end else if (en) begin
			vld_sa <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_sa <= in_tag;
			an_sa  <= in_an;
			den_sa <= in_den;
			x1_sa  <= in_x1;
			n1_sa  <= n1_c;
			n2_sa  <= n2_c;
		end
	end

	// Stage B: x^2 = N/(2a) is negative when N is nonzero and its sign
	// differs from the sign of a.
	assign m1_c   = n1_sa[NBW-1] ? XW'(NBW'(0) - n1_sa) : n1_sa[XW-1:0];
	assign m2_c   = n2_sa[NBW-1] ? XW'(NBW'(0) - n2_sa) : n2_sa[XW-1:0];
	assign neg1_c = (n1_sa != '0) && (n1_sa[NBW-1] != an_sa);
	assign neg2_c = (n2_sa != '0) && (n2_sa[NBW-1] != an_sa);

	always_comb begin
		tag_c  = tag_sa;
		num1_c = x1_sa;
		num2_c = x1_sa;
		if (tag_sa.kind == brs_pkg::KIND_SOLVE) begin
			num1_c = m1_c;
			num2_c = m2_c;
			priority if (neg1_c && neg2_c) begin
				tag_c.code = brs_pkg::CODE_NO_ROOT;
				tag_c.kind = brs_pkg::KIND_NONE;
			end else if (neg1_c) begin
				tag_c.code = brs_pkg::CODE_TWO;
				tag_c.kind = brs_pkg::KIND_PAIR2;
			end else if (neg2_c) begin
				tag_c.code = brs_pkg::CODE_TWO;
				tag_c.kind = brs_pkg::KIND_PAIR1;
			end else begin
				tag_c.code = brs_pkg::CODE_FOUR;
				tag_c.kind = brs_pkg::KIND_QUAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_tag  <= tag_c;
			out_num1 <= num1_c;
			out_num2 <= num2_c;
			out_den  <= den_sa;
		end
	end

endmodule

/* sv/brs_emit.sv */
// ----------------------------------------------------------------------------
// brs_emit: result sequencer
// Holds the finished roots of one request and sends its one to four results
// in order. Its readiness for the next request drives the pipeline advance.
// ----------------------------------------------------------------------------
module brs_emit #(
	parameter int LANE_WIDTH = 25
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  brs_pkg::brs_tag_t       in_tag,
	input  logic [LANE_WIDTH-1:0]   in_r1,
	input  logic [LANE_WIDTH-1:0]   in_r2,
	output logic                    take,
	brs_out_if.source               roots
);

	localparam int RW = brs_pkg::ROOT_WIDTH;

	logic                 busy_q;
	logic [1:0]           idx_q;
	brs_pkg::brs_code_t   code_q;
	brs_pkg::brs_kind_t   kind_q;
	logic [RW-1:0]        mag1_q, mag2_q;

	logic                 sat1, sat2;
	logic [RW-1:0]        lim1, lim2;
	logic                 last_c, done;
	logic [RW-1:0]        mag_c;

	// Saturate lane roots to the largest positive root.
	assign sat1 = (in_r1 >> (RW - 1)) != '0;
	assign sat2 = (in_r2 >> (RW - 1)) != '0;
	assign lim1 = sat1 ? brs_pkg::ROOT_MAX : RW'(in_r1);
	assign lim2 = sat2 ? brs_pkg::ROOT_MAX : RW'(in_r2);

	// Last result of the held request.
	always_comb begin
		unique case (kind_q)
			brs_pkg::KIND_PAIR1,
			brs_pkg::KIND_PAIR2: last_c = idx_q[0];
			brs_pkg::KIND_QUAD:  last_c = (idx_q == 2'd3);
			default:             last_c = 1'b1;
		endcase
	end

	assign done = busy_q && roots.ready && last_c;
	assign take = !busy_q || done;

	// Control: busy flag and result index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			busy_q <= in_valid;
			idx_q  <= 2'd0;
		end else if (roots.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Payload of the held request; lanes that carry no root read as zero.
	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			code_q <= in_tag.code;
			kind_q <= in_tag.kind;
			mag1_q <= (in_tag.kind == brs_pkg::KIND_PAIR1 ||
			           in_tag.kind == brs_pkg::KIND_QUAD) ? lim1 : '0;
			mag2_q <= (in_tag.kind == brs_pkg::KIND_PAIR2 ||
			           in_tag.kind == brs_pkg::KIND_QUAD) ? lim2 : '0;
		end
	end

	// Results go out as +r then -r for each pair.
	assign mag_c = (idx_q[1] || kind_q == brs_pkg::KIND_PAIR2) ? mag2_q : mag1_q;

	assign roots.valid       = busy_q;
	assign roots.case_code   = code_q;
	assign roots.root_value  = idx_q[0] ? (RW'(0) - mag_c) : mag_c;
	assign roots.root_valid  = (kind_q != brs_pkg::KIND_NONE);
	assign roots.last_result = last_c;

endmodule
